>>> design/fust_pkg.sv
// ----------------------------------------------------------------------------
// fust_pkg
// shared constants and types for the first unique symbol tracker
// ----------------------------------------------------------------------------
package fust_pkg;

    localparam int ALPHABET = 26;
    localparam int LETTER_W = 5;
    localparam int LEN_W    = $clog2(ALPHABET + 1);

    typedef logic [LETTER_W-1:0] t_letter;

    typedef struct packed {
        t_letter letter;
        logic    first_of_stream;
    } t_item;

    typedef struct packed {
        logic    found;
        t_letter oldest_unique;
    } t_result;

endpackage

>>> design/fust_in_reg.sv
// ----------------------------------------------------------------------------
// fust_in_reg
// input register stage, takes a new transaction whenever it empties
// ----------------------------------------------------------------------------
module fust_in_reg import fust_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  take;

    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> design/fust_tracker.sv
// ----------------------------------------------------------------------------
// fust_tracker
// arrival list and letter flags, combinational update and oldest pick
// ----------------------------------------------------------------------------
module fust_tracker import fust_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    t_letter             r_order [ALPHABET];
    t_letter             n_order [ALPHABET];
    logic [LEN_W-1:0]    r_len, n_len, cur_len;
    logic [ALPHABET-1:0] r_listed, n_listed, cur_listed;
    logic [ALPHABET-1:0] r_repeated, n_repeated, cur_repeated;
    logic [ALPHABET-1:0] sym_hot, match, at_or_below;
    logic                in_range, do_append, do_remove;

    // position at or past the removed entry moves up by one
    for (genvar g = 0; g < ALPHABET; g++) begin : g_prefix
        assign at_or_below[g] = |match[g:0];
    end

    always_comb begin
        cur_len      = i_item.first_of_stream ? '0 : r_len;
        cur_listed   = i_item.first_of_stream ? '0 : r_listed;
        cur_repeated = i_item.first_of_stream ? '0 : r_repeated;
        in_range     = int'(i_item.letter) < ALPHABET;

        for (int i = 0; i < ALPHABET; i++) begin
            sym_hot[i] = in_range && (i_item.letter == LETTER_W'(i));
            match[i]   = (LEN_W'(i) < cur_len) && (r_order[i] == i_item.letter);
        end

        do_append = |(sym_hot & ~cur_listed & ~cur_repeated);
        do_remove = |(sym_hot & cur_listed & ~cur_repeated);

        for (int i = 0; i < ALPHABET - 1; i++) begin
            if (do_remove && at_or_below[i]) begin
                n_order[i] = r_order[i+1];
            end else if (do_append && (cur_len == LEN_W'(i))) begin
                n_order[i] = i_item.letter;
            end else begin
                n_order[i] = r_order[i];
            end
        end
        if (do_append && (cur_len == LEN_W'(ALPHABET - 1))) begin
            n_order[ALPHABET-1] = i_item.letter;
        end else begin
            n_order[ALPHABET-1] = r_order[ALPHABET-1];
        end

        if (do_append) begin
            n_len = cur_len + LEN_W'(1);
        end else if (do_remove) begin
            n_len = cur_len - LEN_W'(1);
        end else begin
            n_len = cur_len;
        end

        n_listed   = (cur_listed | (do_append ? sym_hot : '0)) & ~(do_remove ? sym_hot : '0);
        n_repeated = cur_repeated | (do_remove ? sym_hot : '0);

        o_result.found         = (n_len != '0);
        o_result.oldest_unique = o_result.found ? n_order[0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_listed   <= '0;
            r_repeated <= '0;
        end else if (i_fire) begin
            r_len      <= n_len;
            r_listed   <= n_listed;
            r_repeated <= n_repeated;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_order <= n_order;
        end
    end

endmodule

>>> design/fust_out_reg.sv
// ----------------------------------------------------------------------------
// fust_out_reg
// result register, holds a stalled transaction and frees on take
// ----------------------------------------------------------------------------
module fust_out_reg import fust_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> design/first_unique_symbol_tracker_unit.sv
// ----------------------------------------------------------------------------
// first_unique_symbol_tracker_unit
// reports, after every letter, the oldest letter seen exactly once so far
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_letter, i_first_of_stream
//  out     | from block| o_out_valid / i_out_stall| o_found, o_oldest_unique
//
//  one transaction in per cycle while o_in_stall is low, one result out per transaction
//  path: input register, then list update into result register
//  the list update and oldest pick are one pass of logic over the 26 entries
//  synchronous active-low reset empties both registers and clears list and flags
//  a stall on the output backs up into o_in_stall in the same cycle
// ----------------------------------------------------------------------------
module first_unique_symbol_tracker_unit import fust_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_letter i_letter,
    input  logic    i_first_of_stream,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output logic    o_found,
    output t_letter o_oldest_unique
);

    t_item   in_item, stage_item;
    t_result next_result, out_result;
    logic    stage_valid;
    logic    out_free;
    logic    fire;

    assign in_item.letter          = i_letter;
    assign in_item.first_of_stream = i_first_of_stream;

    // the staged transaction moves on as soon as the result register can take it
    assign fire = stage_valid && out_free;

    fust_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (in_item),
        .i_advance (out_free),
        .o_stall   (o_in_stall),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    // list state commits on fire, result is taken from the updated list
    fust_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_result (next_result)
    );

    fust_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (stage_valid),
        .i_result (next_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_found         = out_result.found;
    assign o_oldest_unique = out_result.oldest_unique;

endmodule

>>> design/fust_checker.sv
// ----------------------------------------------------------------------------
// fust_checker
// port level checks for the first unique symbol tracker
// ----------------------------------------------------------------------------
module fust_checker import fust_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_in_stall,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input logic    o_found,
    input t_letter o_oldest_unique
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_found)
            && $stable(o_oldest_unique))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_oldest_unique == '0)
        else $error("empty answer carries a letter");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> int'(o_oldest_unique) < ALPHABET)
        else $error("reported letter out of range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> i_out_stall)
        else $error("input stalled without output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind first_unique_symbol_tracker_unit fust_checker u_fust_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_found           (o_found),
    .o_oldest_unique   (o_oldest_unique)
);

>>> dv/first_unique_symbol_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// first_unique_symbol_tracker_unit_tb
// drives letter streams into the tracker and checks every answer against an
// in-bench copy of the arrival list, with random idling on both channels
// ----------------------------------------------------------------------------
module first_unique_symbol_tracker_unit_tb;
    import fust_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 10;

    logic    i_clk             = 1'b0;
    logic    i_rst_n           = 1'b0;
    logic    i_in_valid        = 1'b0;
    logic    o_in_stall;
    t_letter i_letter          = '0;
    logic    i_first_of_stream = 1'b0;
    logic    o_out_valid;
    logic    i_out_stall       = 1'b0;
    logic    o_found;
    t_letter o_oldest_unique;

    // tracker copy: letters seen once, oldest first
    t_letter              once_order [ALPHABET];
    int                   once_count = 0;
    logic [ALPHABET-1:0]  on_list    = '0;
    logic [ALPHABET-1:0]  repeated   = '0;

    t_result expected_answers [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      stall_left     = 0;
    bit      idle_on        = 1'b1;

    first_unique_symbol_tracker_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_letter         (i_letter),
        .i_first_of_stream(i_first_of_stream),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found          (o_found),
        .o_oldest_unique  (o_oldest_unique)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_result next_oldest_unique(t_letter sym, logic start);
        t_result r;
        int      w;
        if (start) begin
            once_count = 0;
            on_list    = '0;
            repeated   = '0;
        end
        if (sym < ALPHABET && !repeated[sym]) begin
            if (!on_list[sym]) begin
                if (once_count < ALPHABET) begin
                    once_order[once_count] = sym;
                    once_count++;
                end
                on_list[sym] = 1'b1;
            end else begin
                // second sighting: squeeze the letter out of the list
                w = 0;
                for (int i = 0; i < once_count; i++) begin
                    if (once_order[i] != sym) begin
                        once_order[w] = once_order[i];
                        w++;
                    end
                end
                once_count    = w;
                on_list[sym]  = 1'b0;
                repeated[sym] = 1'b1;
            end
        end
        r.found         = (once_count > 0);
        r.oldest_unique = (once_count > 0) ? once_order[0] : '0;
        return r;
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic send_letter(input int sym, input bit start);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_letter          <= t_letter'(sym);
        i_first_of_stream <= start;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        expected_answers.insert(expected_answers.size(),
                                next_oldest_unique(t_letter'(sym), start));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_answers.size() != 0) @(negedge i_clk);
    endtask

    // output stall bursts of random length
    always @(negedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 18);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // answer checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_answers.size() == 0) begin
                $error("unexpected transaction: found=%0d oldest_unique=%0d",
                       o_found, o_oldest_unique);
                mismatch_count++;
            end else begin
                want = expected_answers.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_found);
                    mismatch_count++;
                end
                if (o_oldest_unique !== want.oldest_unique) begin
                    $error("oldest_unique: expected %0d, actual %0d",
                           want.oldest_unique, o_oldest_unique);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed_edges();
        send_letter(0, 1'b1);
        send_letter(25, 1'b0);
        send_letter(0, 1'b0);      // repeat drops the head
        send_letter(0, 1'b0);      // already repeated, no change
        send_letter(25, 1'b0);     // list goes empty
        send_letter(25, 1'b0);
        send_letter(31, 1'b0);     // out of range, state kept
        send_letter(26, 1'b0);
        send_letter(7, 1'b0);
        send_letter(30, 1'b0);
        send_letter(31, 1'b1);     // new stream, out-of-range letter still clears
        send_letter(7, 1'b0);
        send_letter(7, 1'b1);      // restart with a letter already on the list
        send_letter(16, 1'b0);
        send_letter(15, 1'b0);
        send_letter(16, 1'b0);     // remove from the middle of the list
        send_letter(1, 1'b0);
        send_letter(15, 1'b0);
        send_letter(0, 1'b1);
        send_letter(0, 1'b1);      // restart on the same letter
    endtask

    task automatic test_drain_pause();
        send_letter(3, 1'b1);
        send_letter(4, 1'b0);
        send_letter(3, 1'b0);
        wait_drained();
        repeat ($urandom_range(5, 30)) @(negedge i_clk);
        send_letter(4, 1'b0);
        send_letter(5, 1'b0);
    endtask

    task automatic send_permutation(input bit start);
        int perm [ALPHABET];
        int j;
        int t;
        for (int i = 0; i < ALPHABET; i++) perm[i] = i;
        for (int i = ALPHABET - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < ALPHABET; i++) send_letter(perm[i], start && i == 0);
    endtask

    task automatic test_random_streams(input int budget);
        int sent;
        int kind;
        int len;
        int base;
        int span;
        int sym;
        sent = 0;
        while (sent < budget) begin
            idle_on = ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                // full alphabet then a second shuffled pass: list fills and empties
                send_permutation(1'b1);
                send_permutation(1'b0);
                sent += 2 * ALPHABET;
            end else if (kind < 9) begin
                len  = $urandom_range(1, 60);
                base = $urandom_range(0, ALPHABET - 1);
                span = $urandom_range(1, ALPHABET);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 19) == 0) sym = $urandom_range(ALPHABET, 31);
                    else sym = (base + $urandom_range(0, span - 1)) % ALPHABET;
                    send_letter(sym, i == 0);
                end
                sent += len;
            end else begin
                // noise: random letters and stray stream starts
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    send_letter($urandom_range(0, 31), $urandom_range(0, 5) == 0);
                sent += len;
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_no_idle_tail(input int count);
        idle_on = 1'b0;
        send_permutation(1'b1);
        for (int i = 0; i < count; i++)
            send_letter($urandom_range(0, 31), $urandom_range(0, 15) == 0);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_edges();
        test_drain_pause();
        test_random_streams(1700);
        test_no_idle_tail(100);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
design/fust_pkg.sv
design/fust_in_reg.sv
design/fust_tracker.sv
design/fust_out_reg.sv
design/first_unique_symbol_tracker_unit.sv
design/fust_checker.sv
dv/first_unique_symbol_tracker_unit_tb.sv
